### rtl/core/enst_pkg.sv
`default_nettype none

package enst_pkg;

  // Geometry and field widths.
  localparam int MAX_WIDTH      = 1024;
  localparam int MAG_BITS       = 15;
  localparam int ANGLE_BITS     = 9;
  localparam int CLASS_BITS     = 3;
  localparam int COL_BITS       = $clog2(MAX_WIDTH);
  localparam int ROW_BITS       = 12;
  localparam int WIDTH_BITS     = 11;
  localparam int CFG_ADDR_BITS  = 2;
  localparam int CFG_DATA_BITS  = 15;

  // Smallest frame the window logic can handle.
  localparam int MIN_DIM = 3;

  // Configuration register addresses.
  localparam logic [CFG_ADDR_BITS-1:0] CFG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_HIGH_THRESHOLD = 2'd2;

  // Edge class codes.
  localparam logic [CLASS_BITS-1:0] CLASS_NONE       = 3'd0;
  localparam logic [CLASS_BITS-1:0] CLASS_HORIZONTAL = 3'd1;
  localparam logic [CLASS_BITS-1:0] CLASS_VERTICAL   = 3'd2;
  localparam logic [CLASS_BITS-1:0] CLASS_POS_DIAG   = 3'd3;
  localparam logic [CLASS_BITS-1:0] CLASS_NEG_DIAG   = 3'd4;

  // Sector limits in whole degrees; the half-degree boundaries round this way.
  localparam logic [ANGLE_BITS-1:0] ANGLE_LIM_0 = 9'd22;
  localparam logic [ANGLE_BITS-1:0] ANGLE_LIM_1 = 9'd67;
  localparam logic [ANGLE_BITS-1:0] ANGLE_LIM_2 = 9'd112;
  localparam logic [ANGLE_BITS-1:0] ANGLE_LIM_3 = 9'd157;
  localparam logic [ANGLE_BITS-1:0] ANGLE_LIM_4 = 9'd202;
  localparam logic [ANGLE_BITS-1:0] ANGLE_LIM_5 = 9'd247;
  localparam logic [ANGLE_BITS-1:0] ANGLE_LIM_6 = 9'd292;
  localparam logic [ANGLE_BITS-1:0] ANGLE_WRAP  = 9'd338;

  // One pixel as it is kept in the line stores and the window.
  typedef struct packed {
    logic [MAG_BITS-1:0]   mag;
    logic [CLASS_BITS-1:0] cls;
    logic                  mask;
  } pix_word_t;

  // One line store entry: the pixel two rows up and the pixel one row up.
  typedef struct packed {
    pix_word_t older;
    pix_word_t newer;
  } line_entry_t;

  typedef struct packed {
    logic                en;
    logic [COL_BITS-1:0] addr;
    line_entry_t         data;
  } ls_write_t;

  function automatic logic [CLASS_BITS-1:0] angle_class(input logic [ANGLE_BITS-1:0] a);
    logic [CLASS_BITS-1:0] c;
    if (a >= ANGLE_WRAP || a <= ANGLE_LIM_0) c = CLASS_VERTICAL;
    else if (a <= ANGLE_LIM_1) c = CLASS_NEG_DIAG;
    else if (a <= ANGLE_LIM_2) c = CLASS_HORIZONTAL;
    else if (a <= ANGLE_LIM_3) c = CLASS_POS_DIAG;
    else if (a <= ANGLE_LIM_4) c = CLASS_VERTICAL;
    else if (a <= ANGLE_LIM_5) c = CLASS_NEG_DIAG;
    else if (a <= ANGLE_LIM_6) c = CLASS_HORIZONTAL;
    else c = CLASS_POS_DIAG;
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/core/enst_if.sv
`default_nettype none

interface enst_pixel_if;
  import enst_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [MAG_BITS-1:0]   gradient_magnitude;
  logic [ANGLE_BITS-1:0] gradient_angle;
  logic                  region_mask;

  modport source (output valid, gradient_magnitude, gradient_angle, region_mask,
                  input ready);
  modport sink   (input valid, gradient_magnitude, gradient_angle, region_mask,
                  output ready);
endinterface

interface enst_result_if;
  import enst_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CLASS_BITS-1:0] edge_class;
  logic [ROW_BITS-1:0]   pixel_row;
  logic [COL_BITS-1:0]   pixel_col;

  modport source (output valid, edge_class, pixel_row, pixel_col, input ready);
  modport sink   (input valid, edge_class, pixel_row, pixel_col, output ready);
endinterface

interface enst_cfg_if;
  import enst_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CFG_ADDR_BITS-1:0] addr;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

### rtl/core/enst_line_store.sv
`default_nettype none

module enst_line_store (
  input  wire logic                            clk,
  input  wire enst_pkg::ls_write_t             wr,
  input  wire logic                            rd_en,
  input  wire logic [enst_pkg::COL_BITS-1:0]   rd_addr,
  output      enst_pkg::line_entry_t           rd_data
);
  import enst_pkg::*;

  // Both previous rows share one entry per column.
  line_entry_t mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/edge_nonmax_suppress_threshold.sv
`default_nettype none

// Streaming non-maximum suppression with a high threshold.
// Gradient pixels arrive in raster order on the pixel channel, one word per
// valid/ready handshake. Each word carries a magnitude, an angle in whole
// degrees and a region mask. For every accepted pixel at row >= 2 and
// column >= 2 the result channel delivers one word with the edge class of
// the pixel one row up and one column left, plus its row and column. Other
// pixels produce no result word; the frame border is never reported.
// Configuration (width, height, high threshold) is written over the cfg
// channel, which is always ready, and must only be written while idle.
// Throughput is one pixel per clock unless the receiver stalls. The pipeline
// has an input stage that holds the line store read, a 3x3 window stage and
// the result register; a pixel's result word passes through them in order.
// When the receiver stalls, the result register holds and the stages behind
// it keep filling; pixels that produce no result still drain, and the pixel
// channel drops ready only once the input stage is blocked.
// Reset clears the counters, the window and the configuration (width 1024,
// height 4095, threshold 0). The line store needs no clearing pass.
module edge_nonmax_suppress_threshold (
  input wire logic     clk,
  input wire logic     rst,
  enst_pixel_if.sink   pixel,
  enst_result_if.source result,
  enst_cfg_if.sink     cfg
);
  import enst_pkg::*;

  // Configuration registers.
  logic [WIDTH_BITS-1:0] image_width;
  logic [ROW_BITS-1:0]   image_height;
  logic [MAG_BITS-1:0]   high_threshold;

  // Position of the next incoming pixel.
  logic [COL_BITS-1:0] col_cnt;
  logic [ROW_BITS-1:0] row_cnt;

  // Input stage: the new pixel, its column and where its result will point.
  logic                s1_valid;
  pix_word_t           s1_word;
  logic [COL_BITS-1:0] s1_col;
  logic                s1_emit;
  logic [ROW_BITS-1:0] s1_out_row;
  logic [COL_BITS-1:0] s1_out_col;

  // Window stage. win[0] is two rows up, win[2] the current row; column 0
  // is the oldest. The decision is pending while s2_valid is set.
  pix_word_t           win [3][3];
  logic                s2_valid;
  logic                s2_emit;
  logic [ROW_BITS-1:0] s2_out_row;
  logic [COL_BITS-1:0] s2_out_col;

  // Result register.
  logic                  out_valid;
  logic [CLASS_BITS-1:0] out_class;
  logic [ROW_BITS-1:0]   out_row;
  logic [COL_BITS-1:0]   out_col;

  logic        in_fire;
  logic        s1_fire;
  logic        s2_adv;
  logic        s2_free;
  logic        out_load_ok;
  ls_write_t   ls_wr;
  line_entry_t ls_rd;

  pix_word_t             in_word;
  logic [WIDTH_BITS-1:0] width_eff;
  logic [ROW_BITS-1:0]   height_eff;
  logic [WIDTH_BITS-1:0] col_step;
  logic [ROW_BITS:0]     row_step;
  logic                  col_wrap;
  logic                  row_wrap;

  pix_word_t             center;
  pix_word_t             nbr_a;
  pix_word_t             nbr_b;
  logic [CLASS_BITS-1:0] decision;

  // Handshake and stage flow.
  assign cfg.ready   = 1'b1;
  assign out_load_ok = !out_valid || result.ready;
  // A window decision leaves when it needs no result slot or one is free.
  assign s2_adv      = s2_valid && (!s2_emit || out_load_ok);
  assign s2_free     = !s2_valid || s2_adv;
  assign s1_fire     = s1_valid && s2_free;
  assign pixel.ready = !s1_valid || s1_fire;
  assign in_fire     = pixel.valid && pixel.ready;

  assign result.valid      = out_valid;
  assign result.edge_class = out_class;
  assign result.pixel_row  = out_row;
  assign result.pixel_col  = out_col;

  // Pack the incoming pixel; a masked pixel carries no class.
  always_comb begin
    in_word.mag  = pixel.gradient_magnitude;
    in_word.cls  = pixel.region_mask ? angle_class(pixel.gradient_angle) : CLASS_NONE;
    in_word.mask = pixel.region_mask;
  end

  // Out-of-range geometry is clamped to what the window can handle.
  always_comb begin
    if (image_width < WIDTH_BITS'(MIN_DIM)) begin
      width_eff = WIDTH_BITS'(MIN_DIM);
    end else if (image_width > WIDTH_BITS'(MAX_WIDTH)) begin
      width_eff = WIDTH_BITS'(MAX_WIDTH);
    end else begin
      width_eff = image_width;
    end
    if (image_height < ROW_BITS'(MIN_DIM)) begin
      height_eff = ROW_BITS'(MIN_DIM);
    end else begin
      height_eff = image_height;
    end
    col_step = WIDTH_BITS'(col_cnt) + WIDTH_BITS'(1);
    row_step = {1'b0, row_cnt} + (ROW_BITS + 1)'(1);
    col_wrap = col_step >= width_eff;
    row_wrap = row_step >= {1'b0, height_eff};
  end

  // The line store is read when a pixel is accepted and written back when
  // that pixel moves into the window, with the old upper row shifted down.
  assign ls_wr.en         = s1_fire;
  assign ls_wr.addr       = s1_col;
  assign ls_wr.data.older = ls_rd.newer;
  assign ls_wr.data.newer = s1_word;

  enst_line_store u_line_store (
    .clk     (clk),
    .wr      (ls_wr),
    .rd_en   (in_fire),
    .rd_addr (col_cnt),
    .rd_data (ls_rd)
  );

  // Suppression decision on the center of the window.
  always_comb begin
    center = win[1][1];
    case (center.cls)
      CLASS_VERTICAL: begin
        nbr_a = win[1][0];
        nbr_b = win[1][2];
      end
      CLASS_HORIZONTAL: begin
        nbr_a = win[0][1];
        nbr_b = win[2][1];
      end
      CLASS_POS_DIAG: begin
        nbr_a = win[0][0];
        nbr_b = win[2][2];
      end
      default: begin
        nbr_a = win[2][0];
        nbr_b = win[0][2];
      end
    endcase
    if (!center.mask || center.cls == CLASS_NONE) begin
      decision = CLASS_NONE;
    end else if (nbr_a.mag > center.mag || nbr_b.mag > center.mag) begin
      decision = CLASS_NONE;
    end else if (center.mag < high_threshold) begin
      decision = CLASS_NONE;
    end else begin
      decision = center.cls;
    end
  end

  // Configuration and position counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= WIDTH_BITS'(MAX_WIDTH);
      image_height   <= '1;
      high_threshold <= '0;
      col_cnt        <= '0;
      row_cnt        <= '0;
    end else begin
      if (cfg.valid) begin
        case (cfg.addr)
          CFG_IMAGE_WIDTH:    image_width    <= cfg.data[WIDTH_BITS-1:0];
          CFG_IMAGE_HEIGHT:   image_height   <= cfg.data[ROW_BITS-1:0];
          CFG_HIGH_THRESHOLD: high_threshold <= cfg.data[MAG_BITS-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        if (col_wrap) begin
          col_cnt <= '0;
          row_cnt <= row_wrap ? '0 : row_step[ROW_BITS-1:0];
        end else begin
          col_cnt <= col_step[COL_BITS-1:0];
        end
      end
    end
  end

  // Input stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_word    <= in_word;
      s1_col     <= col_cnt;
      s1_emit    <= (row_cnt >= ROW_BITS'(2)) && (col_cnt >= COL_BITS'(2));
      s1_out_row <= row_cnt - ROW_BITS'(1);
      s1_out_col <= col_cnt - COL_BITS'(1);
    end
  end

  // Window stage: shift one column in for every pixel that moves forward.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else begin
      if (s1_fire) begin
        s2_valid <= 1'b1;
        for (int r = 0; r < 3; r++) begin
          win[r][0] <= win[r][1];
          win[r][1] <= win[r][2];
        end
        win[0][2] <= ls_rd.older;
        win[1][2] <= ls_rd.newer;
        win[2][2] <= s1_word;
      end else if (s2_adv) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      s2_emit    <= s1_emit;
      s2_out_row <= s1_out_row;
      s2_out_col <= s1_out_col;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_adv && s2_emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s2_emit) begin
      out_class <= decision;
      out_row   <= s2_out_row;
      out_col   <= s2_out_col;
    end
  end

endmodule

`default_nettype wire
